@@ sv/alph_pkg.sv @@
package alph_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned ProdW = CntW + GainW;
  localparam int unsigned LuxW  = 29;

  localparam logic [LuxW-1:0] LuxMax = {LuxW{1'b1}};

  // Reset values of the configuration registers.
  localparam logic [GainW-1:0] VisGainFirstRst  = 16'd4935;
  localparam logic [GainW-1:0] IrGainFirstRst   = 16'd1152;
  localparam logic [GainW-1:0] VisGainSecondRst = 16'd3109;
  localparam logic [GainW-1:0] IrGainSecondRst  = 16'd658;
  localparam logic [CntW-1:0]  NearThrRst       = 16'd213;
  localparam logic [CntW-1:0]  FarThrRst        = 16'd96;

  localparam logic KindLux  = 1'b0;
  localparam logic KindProx = 1'b1;

  typedef enum logic [1:0] {
    REQ_SAMPLE        = 2'd0,
    REQ_LIGHT_RESTART = 2'd1,
    REQ_PROX_RESTART  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    CFG_VIS_GAIN_FIRST  = 3'd0,
    CFG_IR_GAIN_FIRST   = 3'd1,
    CFG_VIS_GAIN_SECOND = 3'd2,
    CFG_IR_GAIN_SECOND  = 3'd3,
    CFG_NEAR_THR        = 3'd4,
    CFG_FAR_THR         = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PHASE_INIT = 2'd0,
    PHASE_NEAR = 2'd1,
    PHASE_FAR  = 2'd2
  } phase_e;

  typedef struct packed {
    logic load_s1;
    logic load_s2;
  } pipe_ctl_t;

endpackage

@@ sv/alph_lux_path.sv @@
module alph_lux_path (
  input  logic                          clk_i,
  input  alph_pkg::pipe_ctl_t           ctl_i,
  input  logic [alph_pkg::CntW-1:0]     visible_count_i,
  input  logic [alph_pkg::CntW-1:0]     infrared_count_i,
  input  logic [alph_pkg::GainW-1:0]    vis_gain_first_i,
  input  logic [alph_pkg::GainW-1:0]    ir_gain_first_i,
  input  logic [alph_pkg::GainW-1:0]    vis_gain_second_i,
  input  logic [alph_pkg::GainW-1:0]    ir_gain_second_i,
  output logic [alph_pkg::LuxW-1:0]     lux_o
);

  logic [alph_pkg::ProdW-1:0] vis_first_q, ir_first_q, vis_second_q, ir_second_q;
  logic signed [alph_pkg::ProdW:0] term_first, term_second, best;
  logic [alph_pkg::LuxW-1:0] lux_d, lux_q;

  // Stage 1: the four weighted counts.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s1) begin
      vis_first_q  <= visible_count_i  * vis_gain_first_i;
      ir_first_q   <= infrared_count_i * ir_gain_first_i;
      vis_second_q <= visible_count_i  * vis_gain_second_i;
      ir_second_q  <= infrared_count_i * ir_gain_second_i;
    end
  end

  // Stage 2: differences, larger term, clamp to zero and to full scale.
  always_comb begin
    term_first  = $signed({1'b0, vis_first_q})  - $signed({1'b0, ir_first_q});
    term_second = $signed({1'b0, vis_second_q}) - $signed({1'b0, ir_second_q});
    best        = (term_first > term_second) ? term_first : term_second;
    if (best[alph_pkg::ProdW] || (best == '0)) begin
      lux_d = '0;
    end else if (|best[alph_pkg::ProdW-1:alph_pkg::LuxW]) begin
      lux_d = alph_pkg::LuxMax;
    end else begin
      lux_d = best[alph_pkg::LuxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s2) begin
      lux_q <= lux_d;
    end
  end

  assign lux_o = lux_q;

endmodule

@@ sv/als_lux_and_proximity_hysteresis_unit.sv @@
// Channel   Direction  Handshake               Beat contents
// in        sink       in_valid_i / in_stall_o  req_type, light and prox counts, enables
// out       source     out_valid_o / out_stall_i result_kind, lux_value, is_near, last_of_run
// cfg       sink       cfg_we_i                 cfg_index_i selects register, cfg_wdata_i
//
// Three registered stages: weighted products, lux value, then the report stage that
// owns the lux history and the near/far phase and fills the output register.
// An accepted input beat passes stage 1 and stage 2 before it reaches the output register.
// The report stage sends one beat per cycle when the output is not stalled, so a sample
// with lux and proximity reports holds it for both beats; others pass at one per cycle.
// Reset loads the register defaults, clears the lux history and puts the proximity
// phase back to initial. A stall on the output holds the output register and backs
// up through the stages to in_stall_o in the same cycle.
module als_lux_and_proximity_hysteresis_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [alph_pkg::CntW-1:0]     visible_count_i,
  input  logic [alph_pkg::CntW-1:0]     infrared_count_i,
  input  logic [alph_pkg::CntW-1:0]     prox_count_i,
  input  logic                          light_active_i,
  input  logic                          prox_active_i,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [alph_pkg::GainW-1:0]    cfg_wdata_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [alph_pkg::LuxW-1:0]     lux_value_o,
  output logic                          is_near_o,
  output logic                          last_of_run_o
);

  // Configuration registers.
  logic [alph_pkg::GainW-1:0] vis_gain_first_q, ir_gain_first_q;
  logic [alph_pkg::GainW-1:0] vis_gain_second_q, ir_gain_second_q;
  logic [alph_pkg::CntW-1:0]  near_thr_q, far_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_gain_first_q  <= alph_pkg::VisGainFirstRst;
      ir_gain_first_q   <= alph_pkg::IrGainFirstRst;
      vis_gain_second_q <= alph_pkg::VisGainSecondRst;
      ir_gain_second_q  <= alph_pkg::IrGainSecondRst;
      near_thr_q        <= alph_pkg::NearThrRst;
      far_thr_q         <= alph_pkg::FarThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        alph_pkg::CFG_VIS_GAIN_FIRST:  vis_gain_first_q  <= cfg_wdata_i;
        alph_pkg::CFG_IR_GAIN_FIRST:   ir_gain_first_q   <= cfg_wdata_i;
        alph_pkg::CFG_VIS_GAIN_SECOND: vis_gain_second_q <= cfg_wdata_i;
        alph_pkg::CFG_IR_GAIN_SECOND:  ir_gain_second_q  <= cfg_wdata_i;
        alph_pkg::CFG_NEAR_THR:        near_thr_q        <= cfg_wdata_i;
        alph_pkg::CFG_FAR_THR:         far_thr_q         <= cfg_wdata_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Pipeline control.
  alph_pkg::pipe_ctl_t ctl;
  logic s1_valid_q, s2_valid_q;
  logic s1_free, s2_free, s2_retire;

  // Stage 1 and stage 2 control payload (no reset needed).
  logic [1:0] s1_req_q, s2_req_q;
  logic       s1_light_q, s2_light_q, s1_prox_q, s2_prox_q;
  logic       s1_above_near_q, s2_above_near_q, s1_below_far_q, s2_below_far_q;
  logic [alph_pkg::LuxW-1:0] s2_lux;

  // Report stage state.
  logic [alph_pkg::LuxW-1:0] last_lux_q;
  logic                      last_lux_valid_q;
  logic                      lux_done_q;
  alph_pkg::phase_e          phase_q, phase_next;

  // Output register.
  logic                      out_valid_q, out_kind_q, out_near_q, out_last_q;
  logic [alph_pkg::LuxW-1:0] out_lux_q;
  logic                      out_free;

  logic is_sample, lux_want, prox_send, prox_want, prox_near;
  logic emit_lux, emit_prox;

  assign s1_free     = !s1_valid_q || ctl.load_s2;
  assign ctl.load_s1 = in_valid_i && s1_free;
  assign s2_free     = !s2_valid_q || s2_retire;
  assign ctl.load_s2 = s1_valid_q && s2_free;
  assign in_stall_o  = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Compare proximity against both thresholds on the way in.
  always_ff @(posedge clk_i) begin
    if (ctl.load_s1) begin
      s1_req_q        <= req_type_i;
      s1_light_q      <= light_active_i;
      s1_prox_q       <= prox_active_i;
      s1_above_near_q <= prox_count_i > near_thr_q;
      s1_below_far_q  <= prox_count_i < far_thr_q;
    end
    if (ctl.load_s2) begin
      s2_req_q        <= s1_req_q;
      s2_light_q      <= s1_light_q;
      s2_prox_q       <= s1_prox_q;
      s2_above_near_q <= s1_above_near_q;
      s2_below_far_q  <= s1_below_far_q;
    end
  end

  alph_lux_path u_lux_path (
    .clk_i             (clk_i),
    .ctl_i             (ctl),
    .visible_count_i   (visible_count_i),
    .infrared_count_i  (infrared_count_i),
    .vis_gain_first_i  (vis_gain_first_q),
    .ir_gain_first_i   (ir_gain_first_q),
    .vis_gain_second_i (vis_gain_second_q),
    .ir_gain_second_i  (ir_gain_second_q),
    .lux_o             (s2_lux)
  );

  // Near/far hysteresis decision for the item in the report stage.
  always_comb begin
    prox_send  = 1'b1;
    prox_near  = 1'b0;
    phase_next = phase_q;
    unique case (phase_q)
      alph_pkg::PHASE_NEAR: begin
        prox_send  = s2_below_far_q;
        phase_next = s2_below_far_q ? alph_pkg::PHASE_FAR : alph_pkg::PHASE_NEAR;
      end
      alph_pkg::PHASE_FAR: begin
        prox_send  = s2_above_near_q;
        prox_near  = 1'b1;
        phase_next = s2_above_near_q ? alph_pkg::PHASE_NEAR : alph_pkg::PHASE_FAR;
      end
      default: begin
        // initial phase, and the unused code: always report
        prox_near  = s2_above_near_q;
        phase_next = s2_above_near_q ? alph_pkg::PHASE_NEAR : alph_pkg::PHASE_FAR;
      end
    endcase
  end

  // Report the lux beat first, then the proximity beat, one per cycle while not stalled.
  always_comb begin
    is_sample = s2_valid_q && (s2_req_q == alph_pkg::REQ_SAMPLE);
    lux_want  = is_sample && s2_light_q && !lux_done_q &&
                (!last_lux_valid_q || (s2_lux != last_lux_q));
    prox_want = is_sample && s2_prox_q && prox_send;
    out_free  = !out_valid_q || !out_stall_i;
    emit_lux  = out_free && lux_want;
    emit_prox = out_free && !lux_want && prox_want;
    s2_retire = s2_valid_q &&
                ((!lux_want && !prox_want) || emit_prox || (emit_lux && !prox_want));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lux_valid_q <= 1'b0;
      lux_done_q       <= 1'b0;
      phase_q          <= alph_pkg::PHASE_INIT;
    end else begin
      if (ctl.load_s2) begin
        lux_done_q <= 1'b0;
      end else if (emit_lux) begin
        lux_done_q <= 1'b1;
      end
      if (emit_lux) begin
        last_lux_valid_q <= 1'b1;
      end else if (s2_retire && (s2_req_q == alph_pkg::REQ_LIGHT_RESTART)) begin
        last_lux_valid_q <= 1'b0;
      end
      if (emit_prox) begin
        phase_q <= phase_next;
      end else if (s2_retire && (s2_req_q == alph_pkg::REQ_PROX_RESTART)) begin
        phase_q <= alph_pkg::PHASE_INIT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_lux) begin
      last_lux_q <= s2_lux;
    end
  end

  // Output register: load on a new beat, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_lux || emit_prox) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_lux) begin
      out_kind_q <= alph_pkg::KindLux;
      out_lux_q  <= s2_lux;
      out_near_q <= 1'b0;
      out_last_q <= !prox_want;
    end else if (emit_prox) begin
      out_kind_q <= alph_pkg::KindProx;
      out_lux_q  <= '0;
      out_near_q <= prox_near;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign lux_value_o   = out_lux_q;
  assign is_near_o     = out_near_q;
  assign last_of_run_o = out_last_q;

endmodule

@@ sv/alph_checker.sv @@
module alph_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      result_kind_o,
  input logic [alph_pkg::LuxW-1:0] lux_value_o,
  input logic                      is_near_o,
  input logic                      last_of_run_o
);

  // Hold a stalled result beat unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(lux_value_o) && $stable(is_near_o) && $stable(last_of_run_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == alph_pkg::KindProx) |->
      (lux_value_o == '0) && last_of_run_o)
    else $error("proximity beat carries lux or is not last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == alph_pkg::KindLux) |-> !is_near_o)
    else $error("lux beat carries near flag");

  // A lux beat that is not last is followed at once by its proximity beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (result_kind_o == alph_pkg::KindLux) &&
      !last_of_run_o |=> out_valid_o && (result_kind_o == alph_pkg::KindProx))
    else $error("proximity beat missing after lux beat");

endmodule

bind als_lux_and_proximity_hysteresis_unit alph_checker u_alph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_kind_o (result_kind_o),
  .lux_value_o   (lux_value_o),
  .is_near_o     (is_near_o),
  .last_of_run_o (last_of_run_o)
);

@@ tb/tb_als_lux_and_proximity_hysteresis_unit.sv @@
module tb_als_lux_and_proximity_hysteresis_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import alph_pkg::*;

  // Request code that the block must drop without any effect.
  localparam logic [1:0] ReqUndefined = 2'd3;

  localparam int unsigned RandPerPhase  = 321;
  localparam int unsigned DrainCycles   = 8;     // three stages plus margin
  localparam int unsigned HoldCycles    = 80;    // long receiver hold-off
  localparam int unsigned WatchdogLimit = 3000;  // cycles with no beat on either side
  localparam int unsigned MaxPrinted    = 40;

  typedef struct packed {
    logic [1:0]      req;
    logic [CntW-1:0] vis;
    logic [CntW-1:0] ir;
    logic [CntW-1:0] prox;
    logic            light_on;
    logic            prox_on;
  } sensor_beat_t;

  typedef struct packed {
    logic            kind;
    logic [LuxW-1:0] lux;
    logic            near;
    logic            last;
  } report_t;

  // Drive every input to a known value from time zero.
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  sensor_beat_t        in_beat   = '0;
  logic                in_stall;
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [GainW-1:0]    cfg_wdata = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                result_kind;
  logic [LuxW-1:0]     lux_value;
  logic                is_near;
  logic                last_of_run;

  als_lux_and_proximity_hysteresis_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (in_beat.req),
    .visible_count_i  (in_beat.vis),
    .infrared_count_i (in_beat.ir),
    .prox_count_i     (in_beat.prox),
    .light_active_i   (in_beat.light_on),
    .prox_active_i    (in_beat.prox_on),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_kind_o    (result_kind),
    .lux_value_o      (lux_value),
    .is_near_o        (is_near),
    .last_of_run_o    (last_of_run)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lux / proximity predictor: a private copy of the registers and history.
  // ---------------------------------------------------------------------------
  logic [GainW-1:0] cfg_shadow [6];
  logic [LuxW-1:0]  lux_seen       = '0;
  logic             lux_seen_valid = 1'b0;
  phase_e           prox_state     = PHASE_INIT;

  sensor_beat_t beats_to_send [$];
  report_t      reports_due [$];
  int unsigned  beats_queued = 0;
  int unsigned  beats_taken  = 0;
  int unsigned  errors       = 0;

  // Larger of the two weighted channel differences, floored at zero and
  // saturated to the lux width.
  function automatic logic [LuxW-1:0] lux_of(logic [CntW-1:0] vis, logic [CntW-1:0] ir);
    longint t1;
    longint t2;
    longint best;
    t1 = longint'(cfg_shadow[CFG_VIS_GAIN_FIRST]) * longint'(vis)
       - longint'(cfg_shadow[CFG_IR_GAIN_FIRST]) * longint'(ir);
    t2 = longint'(cfg_shadow[CFG_VIS_GAIN_SECOND]) * longint'(vis)
       - longint'(cfg_shadow[CFG_IR_GAIN_SECOND]) * longint'(ir);
    best = (t1 > t2) ? t1 : t2;
    if (best <= 0) return '0;
    if (best > longint'(LuxMax)) return LuxMax;
    return best[LuxW-1:0];
  endfunction

  // Advance the predictor by one accepted beat and queue the reports it causes.
  function automatic void predict_reports(sensor_beat_t b);
    report_t         r [2];
    int              n;
    logic [LuxW-1:0] lux;
    logic            sent;
    logic            near;
    n = 0;
    case (b.req)
      REQ_LIGHT_RESTART: lux_seen_valid = 1'b0;
      REQ_PROX_RESTART:  prox_state = PHASE_INIT;
      REQ_SAMPLE: begin
        if (b.light_on) begin
          lux = lux_of(b.vis, b.ir);
          if (!lux_seen_valid || lux != lux_seen) begin
            r[n] = '{KindLux, lux, 1'b0, 1'b0};
            n++;
            lux_seen       = lux;
            lux_seen_valid = 1'b1;
          end
        end
        if (b.prox_on) begin
          sent = 1'b1;
          near = 1'b0;
          case (prox_state)
            PHASE_NEAR: begin
              if (b.prox < cfg_shadow[CFG_FAR_THR]) prox_state = PHASE_FAR;
              else sent = 1'b0;
            end
            PHASE_FAR: begin
              if (b.prox > cfg_shadow[CFG_NEAR_THR]) begin
                near       = 1'b1;
                prox_state = PHASE_NEAR;
              end else begin
                sent = 1'b0;
              end
            end
            default: begin
              // initial phase always decides and reports
              near       = b.prox > cfg_shadow[CFG_NEAR_THR];
              prox_state = near ? PHASE_NEAR : PHASE_FAR;
            end
          endcase
          if (sent) begin
            r[n] = '{KindProx, '0, near, 1'b0};
            n++;
          end
        end
      end
      default: ;  // undefined request: drop without effect
    endcase
    for (int i = 0; i < n; i++) begin
      r[i].last = (i == n - 1);
      reports_due.push_back(r[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps, fed from beats_to_send.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict on acceptance, while the payload is still on the ports.
      if (in_valid && !in_stall) begin
        predict_reports(in_beat);
        beats_taken++;
      end
      // Hold a stalled beat; otherwise pick the next beat or idle.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          in_beat  <= beats_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result beat and stall on a rotating pattern.
  // ---------------------------------------------------------------------------
  int unsigned hold_asks   = 0;  // bumped by the stimulus to request a long hold-off
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned pat_age     = 0;
  logic [31:0] stall_pat   = '0;
  report_t     due;

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch("result beat with no report expected");
        end else begin
          due = reports_due.pop_front();
          if (result_kind !== due.kind)
            report_mismatch($sformatf("result_kind %b, want %b", result_kind, due.kind));
          if (lux_value !== due.lux)
            report_mismatch($sformatf("lux_value %0d, want %0d", lux_value, due.lux));
          if (is_near !== due.near)
            report_mismatch($sformatf("is_near %b, want %b", is_near, due.near));
          if (last_of_run !== due.last)
            report_mismatch($sformatf("last_of_run %b, want %b", last_of_run, due.last));
        end
      end
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        // long hold-off: let the pipeline fill and back up into in_stall
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pat_age == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pat = '0;  // stretch with no stalls
            1:       stall_pat = $urandom & $urandom;
            default: stall_pat = $urandom;
          endcase
          pat_age = $urandom_range(16, 96);
        end else begin
          pat_age--;
        end
        out_stall <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  int unsigned quiet = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] prev_vis = '0;
  logic [CntW-1:0] prev_ir  = '0;

  function automatic sensor_beat_t mk(logic [1:0] req, logic [CntW-1:0] vis,
                                      logic [CntW-1:0] ir, logic [CntW-1:0] prox,
                                      logic light_on, logic prox_on);
    sensor_beat_t b;
    b = '{req, vis, ir, prox, light_on, prox_on};
    return b;
  endfunction

  task automatic offer(sensor_beat_t b);
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [CntW-1:0] rnd_cnt();
    return CntW'($urandom);
  endfunction

  function automatic logic [CntW-1:0] extreme();
    return $urandom_range(0, 1) ? {CntW{1'b1}} : '0;
  endfunction

  // Mostly samples, with counts biased to repeats, extremes and thresholds.
  function automatic sensor_beat_t random_beat();
    sensor_beat_t b;
    int unsigned  sel;
    sel   = $urandom_range(0, 99);
    b.req = (sel < 80) ? REQ_SAMPLE : (sel < 88) ? REQ_LIGHT_RESTART :
            (sel < 95) ? REQ_PROX_RESTART : ReqUndefined;
    case ($urandom_range(0, 4))
      0: begin b.vis = prev_vis; b.ir = prev_ir; end  // same counts as the last beat
      1: begin b.vis = extreme(); b.ir = extreme(); end
      2: begin b.vis = CntW'($urandom_range(0, 255)); b.ir = CntW'($urandom_range(0, 255)); end
      default: begin b.vis = rnd_cnt(); b.ir = rnd_cnt(); end
    endcase
    case ($urandom_range(0, 3))
      0:       b.prox = CntW'(cfg_shadow[CFG_NEAR_THR] + $urandom_range(0, 4) - 2);
      1:       b.prox = CntW'(cfg_shadow[CFG_FAR_THR] + $urandom_range(0, 4) - 2);
      2:       b.prox = extreme();
      default: b.prox = rnd_cnt();
    endcase
    b.light_on = ($urandom_range(0, 5) != 0);
    b.prox_on  = ($urandom_range(0, 5) != 0);
    prev_vis   = b.vis;
    prev_ir    = b.ir;
    return b;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [GainW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_shadow[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [GainW-1:0] g0, logic [GainW-1:0] g1,
                                logic [GainW-1:0] g2, logic [GainW-1:0] g3,
                                logic [CntW-1:0] near_thr, logic [CntW-1:0] far_thr);
    write_reg(CFG_VIS_GAIN_FIRST, g0);
    write_reg(CFG_IR_GAIN_FIRST, g1);
    write_reg(CFG_VIS_GAIN_SECOND, g2);
    write_reg(CFG_IR_GAIN_SECOND, g3);
    write_reg(CFG_NEAR_THR, near_thr);
    write_reg(CFG_FAR_THR, far_thr);
  endtask

  // Wait until every offered beat is in and every report is out, then let
  // restarts and ignored requests flush through the stages.
  task automatic wait_drained();
    do @(posedge clk);
    while (beats_taken != beats_queued || reports_due.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  int unsigned near_pick;

  initial begin
    cfg_shadow[CFG_VIS_GAIN_FIRST]  = VisGainFirstRst;
    cfg_shadow[CFG_IR_GAIN_FIRST]   = IrGainFirstRst;
    cfg_shadow[CFG_VIS_GAIN_SECOND] = VisGainSecondRst;
    cfg_shadow[CFG_IR_GAIN_SECOND]  = IrGainSecondRst;
    cfg_shadow[CFG_NEAR_THR]        = NearThrRst;
    cfg_shadow[CFG_FAR_THR]         = FarThrRst;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset register values.
    offer(mk(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));  // first lux always sent
    offer(mk(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));  // unchanged: silent
    offer(mk(REQ_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0));
    offer(mk(REQ_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0));  // negative: zero
    offer(mk(REQ_LIGHT_RESTART, rnd_cnt(), rnd_cnt(), rnd_cnt(), 1'b1, 1'b1));
    offer(mk(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));  // forced after restart
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'd0, 1'b0, 1'b1));    // initial phase: far
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'd213, 1'b0, 1'b1));  // at near threshold
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'd214, 1'b0, 1'b1));  // far to near
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'd96, 1'b0, 1'b1));   // at far threshold
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'd95, 1'b0, 1'b1));   // near to far
    offer(mk(REQ_PROX_RESTART, rnd_cnt(), rnd_cnt(), rnd_cnt(), 1'b1, 1'b1));
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'd213, 1'b0, 1'b1));  // initial: far
    offer(mk(REQ_PROX_RESTART, rnd_cnt(), rnd_cnt(), rnd_cnt(), 1'b0, 1'b0));
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'hFFFF, 1'b0, 1'b1)); // initial: near
    offer(mk(REQ_SAMPLE, 16'd1000, 16'd200, 16'd0, 1'b1, 1'b1));       // lux then far
    offer(mk(REQ_SAMPLE, 16'd1000, 16'd200, 16'd0, 1'b1, 1'b1));       // nothing changes
    offer(mk(ReqUndefined, rnd_cnt(), rnd_cnt(), 16'hFFFF, 1'b1, 1'b1)); // dropped
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), 16'hFFFF, 1'b0, 1'b0)); // both parts off
    offer(mk(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));   // lux then near
    offer(mk(REQ_SAMPLE, rnd_cnt(), rnd_cnt(), rnd_cnt(), 1'b1, 1'b0));
    repeat (RandPerPhase) offer(random_beat());
    wait_drained();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          near_pick = $urandom_range(100, 2000);
          apply_settings(rnd_cnt(), rnd_cnt(), rnd_cnt(), rnd_cnt(),
                         CntW'(near_pick), CntW'($urandom_range(0, near_pick)));
        end
        2: apply_settings('1, '1, '1, '1, '1, '0);  // saturating lux, never near
        3: apply_settings('0, '0, '0, '0, '0, '1);  // lux stuck at zero, thresholds overlap
        4: apply_settings(rnd_cnt(), CntW'($urandom_range(0, 255)),
                          CntW'($urandom_range(0, 255)), rnd_cnt(), rnd_cnt(), rnd_cnt());
        default: apply_settings(VisGainFirstRst, IrGainFirstRst, VisGainSecondRst,
                                IrGainSecondRst, NearThrRst, FarThrRst);
      endcase
      if (ph == 2) begin
        offer(mk(REQ_SAMPLE, 16'hFFFF, 16'h0000, 16'd0, 1'b1, 1'b1));  // saturates
        offer(mk(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      end
      repeat (RandPerPhase) offer(random_beat());
      // Hold the receiver off while the queue is full so the input backs up.
      if (ph == 1) hold_asks++;
      wait_drained();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/alph_pkg.sv
sv/alph_lux_path.sv
sv/als_lux_and_proximity_hysteresis_unit.sv
sv/alph_checker.sv
tb/tb_als_lux_and_proximity_hysteresis_unit.sv
